[sv/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the strict UTF-8 to 16-bit decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_OUT
    } utf8d_state_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_NON_BMP = 2'd2,
        ERR_NONCHAR = 2'd3
    } utf8d_err_t;

    localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
    localparam logic [7:0]  LEAD_MIN     = 8'hC2;
    localparam logic [7:0]  LEAD_MAX     = 8'hF4;
    localparam logic [7:0]  CONT_MIN     = 8'h80;
    localparam logic [7:0]  CONT_MAX     = 8'hBF;
    localparam logic [7:0]  E0_SECOND_MIN = 8'hA0;
    localparam logic [7:0]  ED_SECOND_MAX = 8'h9F;
    localparam logic [7:0]  F0_SECOND_MIN = 8'h90;
    localparam logic [7:0]  F4_SECOND_MAX = 8'h8F;
    localparam logic [15:0] NONCHAR_LO   = 16'hFDD0;
    localparam logic [15:0] NONCHAR_HI   = 16'hFDEF;
    localparam logic [15:0] NONCHAR_FFFE = 16'hFFFE;

    // Sequence length announced by a lead byte (1 to 4).
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            if (b < 8'hC0)
            begin
                len = 3'd1;
            end
            else if (b < 8'hE0)
            begin
                len = 3'd2;
            end
            else if (b < 8'hF0)
            begin
                len = 3'd3;
            end
            else
            begin
                len = 3'd4;
            end
            return len;
        end
    endfunction

endpackage

[sv/utf8_decoder_bmp_top.sv]
// ----------------------------------------------------------------------------
// utf8_decoder_bmp_top
// Strict UTF-8 decoder that emits 16-bit BMP code units, one word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid/byte_ready) takes one word per handshake: a
//   raw UTF-8 byte and a string_last mark on the final byte of a string.
//   The unit channel (unit_valid/unit_ready) delivers decoded words: the code
//   unit, its error kind, the first error of the string so far, a mark on the
//   last word caused by the current byte and a mark on the final word of the
//   string. A byte may cause zero to four output words.
//   A byte is accepted in idle and is then evaluated. Each output word is
//   held in the output state until taken, and is followed by another
//   evaluation when another word follows from the same byte; a byte that
//   yields no word returns the block to idle after its evaluation.
//   unit_valid rises when the evaluation state passes to the output state.
//   The rate is set by the single shared sequence checker, which decodes one
//   sequence per evaluation cycle, and by byte_ready being high only in idle.
//   Reset empties the pending byte buffer and clears the sticky error.
//   When the receiver stalls, the decoded word waits in the output register
//   and no further sequence is evaluated until it is taken.
// ----------------------------------------------------------------------------
module utf8_decoder_bmp_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  in_byte,
    input  logic        string_last,
    output logic        unit_valid,
    input  logic        unit_ready,
    output logic [15:0] code_unit,
    output logic [1:0]  error_kind,
    output logic [1:0]  first_error,
    output logic        run_last,
    output logic        string_end
);
    import utf8d_pkg::*;

    utf8d_state_t state_reg, state_next;

    // Byte buffer: up to three pending bytes plus the newly accepted one.
    logic [7:0]  buf_reg [4];
    logic [7:0]  buf_next [4];
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [1:0]  sticky_reg, sticky_next;

    // Output register.
    logic [15:0] code_unit_reg, code_unit_next;
    logic [1:0]  error_kind_reg, error_kind_next;
    logic [1:0]  first_error_reg, first_error_next;
    logic        run_last_reg, run_last_next;
    logic        string_end_reg, string_end_next;

    // Shared sequence checker signals.
    logic [7:0]  lead;
    logic [2:0]  len;
    logic        have_all;
    logic        emit;
    logic        seq_valid;
    logic [15:0] value;
    logic [2:0]  consumed;
    logic [2:0]  remain;
    logic [1:0]  ek;
    logic [15:0] cu;
    logic [7:0]  shifted [4];
    logic        more;
    logic        accept_in;
    logic        accept_out;

    assign accept_in  = byte_valid && byte_ready;
    assign accept_out = unit_valid && unit_ready;

    // Checker: looks at the sequence at the head of the buffer.
    always_comb
    begin
        lead     = buf_reg[0];
        len      = seq_len(lead);
        have_all = (cnt_reg >= len);
        emit     = (cnt_reg != 3'd0) && (have_all || last_reg);

        seq_valid = 1'b1;
        if (lead >= CONT_MIN)
        begin
            if (lead < LEAD_MIN || lead > LEAD_MAX)
            begin
                seq_valid = 1'b0;
            end
            if (lead == 8'hE0 && buf_reg[1] < E0_SECOND_MIN)
            begin
                seq_valid = 1'b0;
            end
            if (lead == 8'hED && buf_reg[1] > ED_SECOND_MAX)
            begin
                seq_valid = 1'b0;
            end
            if (lead == 8'hF0 && buf_reg[1] < F0_SECOND_MIN)
            begin
                seq_valid = 1'b0;
            end
            if (lead == 8'hF4 && buf_reg[1] > F4_SECOND_MAX)
            begin
                seq_valid = 1'b0;
            end
            for (int i = 1; i < 4; i++)
            begin
                if (3'(i) < len && (buf_reg[i] < CONT_MIN || buf_reg[i] > CONT_MAX))
                begin
                    seq_valid = 1'b0;
                end
            end
        end

        unique case (len)
            3'd1:    value = {8'h00, buf_reg[0]};
            3'd2:    value = {5'b0, buf_reg[0][4:0], buf_reg[1][5:0]};
            default: value = {buf_reg[0][3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
        endcase

        if (!have_all || !seq_valid)
        begin
            consumed = 3'd1;
            cu       = REPLACEMENT;
            ek       = ERR_INVALID;
        end
        else
        begin
            consumed = len;
            if (len == 3'd4)
            begin
                // A valid four-byte sequence always lies above the BMP.
                cu = REPLACEMENT;
                ek = ERR_NON_BMP;
            end
            else if (value >= NONCHAR_FFFE
                     || (value >= NONCHAR_LO && value <= NONCHAR_HI))
            begin
                cu = REPLACEMENT;
                ek = ERR_NONCHAR;
            end
            else
            begin
                cu = value;
                ek = ERR_NONE;
            end
        end

        remain = cnt_reg - consumed;
        for (int i = 0; i < 4; i++)
        begin
            shifted[i] = 8'h00;
        end
        unique case (consumed)
            3'd1:
            begin
                shifted[0] = buf_reg[1];
                shifted[1] = buf_reg[2];
                shifted[2] = buf_reg[3];
            end
            3'd2:
            begin
                shifted[0] = buf_reg[2];
                shifted[1] = buf_reg[3];
            end
            3'd3:
            begin
                shifted[0] = buf_reg[3];
            end
            default:
            begin
            end
        endcase

        // Another word follows from this byte if the remaining bytes hold a
        // complete sequence or the string ends here.
        more = (remain != 3'd0) && (last_reg || remain >= seq_len(shifted[0]));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = emit ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (accept_out)
                begin
                    state_next = run_last_reg ? ST_IDLE : ST_EVAL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        cnt_next         = cnt_reg;
        last_next        = last_reg;
        sticky_next      = sticky_reg;
        code_unit_next   = code_unit_reg;
        error_kind_next  = error_kind_reg;
        first_error_next = first_error_reg;
        run_last_next    = run_last_reg;
        string_end_next  = string_end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    buf_next[cnt_reg[1:0]] = in_byte;
                    cnt_next               = cnt_reg + 3'd1;
                    last_next              = string_last;
                end
            end
            ST_EVAL:
            begin
                if (emit)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        buf_next[i] = shifted[i];
                    end
                    cnt_next = remain;
                    if (sticky_reg == ERR_NONE)
                    begin
                        sticky_next = ek;
                    end
                    code_unit_next   = cu;
                    error_kind_next  = ek;
                    first_error_next = (sticky_reg == ERR_NONE) ? ek : sticky_reg;
                    run_last_next    = !more;
                    string_end_next  = !more && last_reg;
                end
            end
            ST_OUT:
            begin
                if (accept_out && string_end_reg)
                begin
                    sticky_next = ERR_NONE;
                    cnt_next    = 3'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 3'd0;
            last_reg   <= 1'b0;
            sticky_reg <= ERR_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
        code_unit_reg   <= code_unit_next;
        error_kind_reg  <= error_kind_next;
        first_error_reg <= first_error_next;
        run_last_reg    <= run_last_next;
        string_end_reg  <= string_end_next;
    end

    assign byte_ready  = (state_reg == ST_IDLE);
    assign unit_valid  = (state_reg == ST_OUT);
    assign code_unit   = code_unit_reg;
    assign error_kind  = error_kind_reg;
    assign first_error = first_error_reg;
    assign run_last    = run_last_reg;
    assign string_end  = string_end_reg;

endmodule
